// File: hw/rtl/pcc_pkg.sv
// Shared types and constants for the palette color cycler.
// No dependencies; imported by every module of the block.
package pcc_pkg;

    localparam int PALETTE_MAX = 8;
    localparam int IDX_W       = $clog2(PALETTE_MAX);
    localparam int COUNT_W     = 4;
    localparam int PAIR_W      = 48;
    localparam int PAIR_N      = PALETTE_MAX / 2;
    localparam int TICK_W      = 32;
    localparam int CHAN_W      = 8;
    localparam int OUT_W       = 6 * CHAN_W;
    localparam int CFG_IDX_W   = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR3 = 3'd5;

    typedef struct packed {
        logic [COUNT_W-1:0]             count;
        logic [TICK_W-1:0]              step;
        logic [PAIR_N-1:0][PAIR_W-1:0]  pair;
    } pcc_cfg_t;

    // Controller commands; at most one is high in any cycle
    typedef struct packed {
        logic take;
        logic mul;
        logic upd;
        logic walk;
        logic sqr;
        logic ease;
        logic blend;
        logic range;
        logic num;
        logic div;
        logic out_load;
    } pcc_cmd_t;

endpackage

// File: hw/rtl/palette_color_cycler.sv
// Palette color cycler: one result beat per input beat. An item passes through
// the accept state, nine sequenced steps (tick delta multiply, phase update,
// palette walk, two easing multiplies, channel blend, range, numerators, output
// load) and eight steps of the shared three-lane restoring divider for the
// tint. The output load waits, and the item takes longer, while the previous
// result still sits unaccepted in the output register. The first beat after
// reset latches the tick but leaves the phase as it was. A finished result waits
// in the output register while the next beat is taken. Configuration writes take
// effect at once; the user must make them only while the block is idle; the block
// does not enforce it. Depends on pcc_pkg, pcc_ctrl and pcc_dpath.
module palette_color_cycler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pcc_pkg::TICK_W-1:0]          s_tdata,   // [31:0] now_tick
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] color_red, [15:8] color_green, [23:16] color_blue,
    // [31:24] tint_red, [39:32] tint_green, [47:40] tint_blue
    output logic [pcc_pkg::OUT_W-1:0]           m_tdata,
    input  logic                                cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pcc_pkg::PAIR_W-1:0]          cfg_data
);
    import pcc_pkg::*;

    pcc_cfg_t cfg_reg;
    pcc_cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count <= COUNT_W'(1);
            cfg_reg.step  <= '0;
            cfg_reg.pair  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COUNT: cfg_reg.count   <= cfg_data[COUNT_W-1:0];
                REG_STEP:  cfg_reg.step    <= cfg_data[TICK_W-1:0];
                REG_PAIR0: cfg_reg.pair[0] <= cfg_data;
                REG_PAIR1: cfg_reg.pair[1] <= cfg_data;
                REG_PAIR2: cfg_reg.pair[2] <= cfg_data;
                REG_PAIR3: cfg_reg.pair[3] <= cfg_data;
                default:   cfg_reg         <= cfg_reg;
            endcase
        end
    end

    pcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pcc_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .now_tick (s_tdata),
        .result   (m_tdata)
    );

endmodule

// File: hw/rtl/pcc_ctrl.sv
// Sequencing controller for the palette color cycler.
// Depends on pcc_pkg; drives the command struct of pcc_dpath.
module pcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output pcc_pkg::pcc_cmd_t cmd
);
    import pcc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_UPD   = 4'd2;
    localparam logic [3:0] ST_WALK  = 4'd3;
    localparam logic [3:0] ST_SQR   = 4'd4;
    localparam logic [3:0] ST_EASE  = 4'd5;
    localparam logic [3:0] ST_BLEND = 4'd6;
    localparam logic [3:0] ST_RANGE = 4'd7;
    localparam logic [3:0] ST_NUM   = 4'd8;
    localparam logic [3:0] ST_DIV   = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    localparam int DIV_STEPS = CHAN_W;

    logic [3:0]                   state_reg, state_next;
    logic [$clog2(DIV_STEPS)-1:0] div_cnt_reg, div_cnt_next;
    logic                         out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk   = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                cmd.sqr    = 1'b1;
                state_next = ST_EASE;
            end
            ST_EASE:
            begin
                cmd.ease   = 1'b1;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                cmd.blend  = 1'b1;
                state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                cmd.range  = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.num      = 1'b1;
                div_cnt_next = '1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div      = 1'b1;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten before taken");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_cnt_reg == '0) |=> (state_reg == ST_DONE))
        else $error("divider did not finish after its last step");

endmodule

// File: hw/rtl/pcc_dpath.sv
// Datapath of the palette color cycler: phase, easing, blend and tint divider.
// Depends on pcc_pkg; steered by the command struct from pcc_ctrl.
module pcc_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pcc_pkg::pcc_cmd_t               cmd,
    input  pcc_pkg::pcc_cfg_t               cfg,
    input  logic [pcc_pkg::TICK_W-1:0]      now_tick,
    output logic [pcc_pkg::OUT_W-1:0]       result
);
    import pcc_pkg::*;

    localparam int WALK_W = TICK_W + COUNT_W;
    localparam int NUM_W  = 2 * CHAN_W;
    localparam int DSH_W  = 2 * CHAN_W - 1;

    // phase state
    logic                      running_reg;
    logic [TICK_W-1:0]         prev_tick_reg;
    logic [TICK_W-1:0]         phase_reg;

    // per-item working registers
    logic [TICK_W-1:0]         tick_reg;
    logic [2*TICK_W-1:0]       prod_reg;
    logic [IDX_W-1:0]          idx_reg, nxt_reg;
    logic [15:0]               f_reg, f2_reg, ease_reg;
    logic [2:0][CHAN_W-1:0]    col_reg;      // [2] red, [1] green, [0] blue
    logic [CHAN_W-1:0]         lo_reg, hi_reg;
    logic                      grey_reg;
    logic [2:0][NUM_W-1:0]     rem_reg;
    logic [2:0][CHAN_W-1:0]    quo_reg;
    logic [DSH_W-1:0]          dsh_reg;
    logic [OUT_W-1:0]          out_reg;

    // tick delta, wrapped modulo 2^32
    logic [TICK_W-1:0]         delta;
    assign delta = tick_reg - prev_tick_reg;

    function automatic logic [23:0] entry_color(input logic [PAIR_N-1:0][PAIR_W-1:0] pair,
                                                input logic [IDX_W-1:0] idx);
        logic [PAIR_W-1:0] p;
        p = pair[idx[IDX_W-1:1]];
        return idx[0] ? p[47:24] : p[23:0];
    endfunction

    // count limited to 1..PALETTE_MAX
    logic [COUNT_W-1:0] cnt;
    always_comb
    begin
        if (cfg.count == '0)
            cnt = COUNT_W'(1);
        else if (cfg.count > COUNT_W'(PALETTE_MAX))
            cnt = COUNT_W'(PALETTE_MAX);
        else
            cnt = cfg.count;
    end

    logic [WALK_W-1:0]  walk;
    logic [COUNT_W-1:0] widx, cidx, nidx;
    assign walk = WALK_W'(phase_reg) * WALK_W'(cnt);
    assign widx = walk[WALK_W-1:TICK_W];
    assign cidx = (widx >= cnt) ? (cnt - 1'b1) : widx;
    assign nidx = ((cidx + 1'b1) == cnt) ? '0 : (cidx + 1'b1);

    logic [31:0] fsq;
    assign fsq = 32'(f_reg) * 32'(f_reg);

    logic [17:0] ease_k;
    logic [33:0] ease_p;
    logic [17:0] ease_s;
    assign ease_k = 18'd196608 - {1'b0, f_reg, 1'b0};
    assign ease_p = 34'(f2_reg) * 34'(ease_k);
    assign ease_s = ease_p[33:16];

    logic [23:0]              from_c, to_c;
    logic [16:0]              inv_e;
    logic [2:0][CHAN_W-1:0]   mix;
    assign from_c = entry_color(cfg.pair, idx_reg);
    assign to_c   = entry_color(cfg.pair, nxt_reg);
    assign inv_e  = 17'h10000 - 17'(ease_reg);

    always_comb
    begin
        logic [25:0] s;
        for (int c = 0; c < 3; c++)
        begin
            s = 26'(from_c[c*CHAN_W +: CHAN_W]) * 26'(inv_e)
              + 26'(to_c[c*CHAN_W +: CHAN_W]) * 26'(ease_reg);
            mix[c] = s[23:16];
        end
    end

    logic [CHAN_W-1:0] lo_c, hi_c;
    always_comb
    begin
        lo_c = col_reg[2];
        hi_c = col_reg[2];
        for (int c = 0; c < 2; c++)
        begin
            if (col_reg[c] < lo_c) lo_c = col_reg[c];
            if (col_reg[c] > hi_c) hi_c = col_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            prev_tick_reg <= '0;
            phase_reg     <= '0;
        end
        else if (cmd.upd)
        begin
            running_reg   <= 1'b1;
            prev_tick_reg <= tick_reg;
            // drop a step of one whole cycle or more
            if (running_reg && prod_reg[2*TICK_W-1:TICK_W] == '0)
                phase_reg <= phase_reg + prod_reg[TICK_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            tick_reg <= now_tick;
        if (cmd.mul)
            prod_reg <= (2*TICK_W)'(delta) * (2*TICK_W)'(cfg.step);
        if (cmd.walk)
        begin
            idx_reg <= cidx[IDX_W-1:0];
            nxt_reg <= nidx[IDX_W-1:0];
            f_reg   <= walk[TICK_W-1:16];
        end
        if (cmd.sqr)
            f2_reg <= fsq[31:16];
        if (cmd.ease)
            ease_reg <= (ease_s > 18'd65535) ? 16'hFFFF : ease_s[15:0];
        if (cmd.blend)
            col_reg <= mix;
        if (cmd.range)
        begin
            lo_reg <= lo_c;
            hi_reg <= hi_c;
        end
        if (cmd.num)
        begin
            for (int c = 0; c < 3; c++)
                rem_reg[c] <= NUM_W'(col_reg[c] - lo_reg) * NUM_W'(hi_reg);
            dsh_reg  <= {hi_reg - lo_reg, 7'b0};
            grey_reg <= (hi_reg == lo_reg);
        end
        if (cmd.div)
        begin
            // one restoring step per lane; quotient fits in a channel
            for (int c = 0; c < 3; c++)
            begin
                if (rem_reg[c] >= NUM_W'(dsh_reg))
                begin
                    rem_reg[c] <= rem_reg[c] - NUM_W'(dsh_reg);
                    quo_reg[c] <= {quo_reg[c][CHAN_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg[c] <= {quo_reg[c][CHAN_W-2:0], 1'b0};
                end
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.out_load)
        begin
            if (grey_reg)
                out_reg <= {col_reg[0], col_reg[1], col_reg[2],
                            col_reg[0], col_reg[1], col_reg[2]};
            else
                out_reg <= {quo_reg[0], quo_reg[1], quo_reg[2],
                            col_reg[0], col_reg[1], col_reg[2]};
        end
    end

    assign result = out_reg;

endmodule

// File: bench/palette_color_cycler_checker.sv
// Checker for the palette color cycler: watches the config port and both stream
// channels, predicts each result beat and compares it channel by channel.
// Depends on pcc_pkg.
`timescale 1ns / 1ps

module palette_color_cycler_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [pcc_pkg::TICK_W-1:0]      s_tdata,    // [31:0] now_tick
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] color_red, [15:8] color_green, [23:16] color_blue,
    // [31:24] tint_red, [39:32] tint_green, [47:40] tint_blue
    input  logic [pcc_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcc_pkg::PAIR_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              colors_pending
);

    import pcc_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0] tint_blue;
        logic [CHAN_W-1:0] tint_green;
        logic [CHAN_W-1:0] tint_red;
        logic [CHAN_W-1:0] color_blue;
        logic [CHAN_W-1:0] color_green;
        logic [CHAN_W-1:0] color_red;
    } color_beat_t;

    // Shadow of the block's registers and cycling state
    logic [COUNT_W-1:0]     shadow_count = 4'd1;
    logic [TICK_W-1:0]      shadow_step  = '0;
    logic [PAIR_W-1:0]      shadow_pair [PAIR_N] = '{default: '0};
    bit                     started      = 1'b0;
    logic [TICK_W-1:0]      prior_tick   = '0;
    logic [TICK_W-1:0]      phase        = '0;

    logic [OUT_W-1:0]       expected_colors [$];
    color_beat_t            want;
    color_beat_t            got;

    function automatic logic [23:0] palette_entry(input int idx);
        logic [PAIR_W-1:0] pair;
        pair = shadow_pair[idx / 2];
        return (idx % 2) ? pair[47:24] : pair[23:0];
    endfunction

    function automatic logic [7:0] mix_channel(input logic [7:0] from_c,
                                               input logic [7:0] to_c,
                                               input logic [31:0] ease);
        logic [31:0] acc;
        acc = 32'(from_c) * (32'd65536 - ease) + 32'(to_c) * ease;
        return acc[23:16];
    endfunction

    function automatic logic [7:0] stretch_channel(input logic [7:0] c,
                                                   input logic [7:0] lo,
                                                   input logic [7:0] hi);
        logic [31:0] q;
        q = (32'(c - lo) * 32'(hi)) / 32'(hi - lo);
        return q[7:0];
    endfunction

    function automatic logic [OUT_W-1:0] predict_color(input logic [TICK_W-1:0] now);
        logic [31:0]    delta;
        logic [63:0]    advance;
        logic [63:0]    walk;
        int             n;
        int             idx;
        int             nxt;
        logic [31:0]    frac;
        logic [31:0]    frac_sq;
        logic [63:0]    eased;
        logic [31:0]    ease;
        logic [23:0]    c_from;
        logic [23:0]    c_to;
        logic [7:0]     lo;
        logic [7:0]     hi;
        color_beat_t    res;

        if (!started)
        begin
            // first beat after reset latches the tick; the phase holds
            started    = 1'b1;
            prior_tick = now;
        end
        else
        begin
            delta      = now - prior_tick;
            advance    = 64'(delta) * 64'(shadow_step);
            prior_tick = now;
            // hold the phase when the advance is a whole cycle or more
            if (advance[63:32] == 32'd0)
                phase = phase + advance[31:0];
        end

        n = shadow_count;
        if (n == 0)
            n = 1;
        if (n > PALETTE_MAX)
            n = PALETTE_MAX;

        walk = 64'(phase) * 64'(n);
        idx  = int'(walk[63:32]);
        if (idx >= n)
            idx = n - 1;
        nxt  = (idx + 1) % n;

        frac    = 32'(walk[31:16]);
        frac_sq = (frac * frac) >> 16;
        eased   = (64'(frac_sq) * 64'(32'd196608 - 2 * frac)) >> 16;
        ease    = (eased > 64'd65535) ? 32'd65535 : eased[31:0];

        c_from = palette_entry(idx);
        c_to   = palette_entry(nxt);
        res.color_red   = mix_channel(c_from[23:16], c_to[23:16], ease);
        res.color_green = mix_channel(c_from[15:8],  c_to[15:8],  ease);
        res.color_blue  = mix_channel(c_from[7:0],   c_to[7:0],   ease);

        lo = res.color_red;
        hi = res.color_red;
        if (res.color_green < lo) lo = res.color_green;
        if (res.color_blue  < lo) lo = res.color_blue;
        if (res.color_green > hi) hi = res.color_green;
        if (res.color_blue  > hi) hi = res.color_blue;

        if (hi == lo)
        begin
            // grey passes through unchanged
            res.tint_red   = res.color_red;
            res.tint_green = res.color_green;
            res.tint_blue  = res.color_blue;
        end
        else
        begin
            res.tint_red   = stretch_channel(res.color_red,   lo, hi);
            res.tint_green = stretch_channel(res.color_green, lo, hi);
            res.tint_blue  = stretch_channel(res.color_blue,  lo, hi);
        end
        return res;
    endfunction

    task automatic check_channel(input string name, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch: expected %02h, got %02h",
                         $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // retire the result first: it never belongs to a beat taken at this edge
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_colors.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat %012h with no item pending",
                                 $realtime, m_tdata);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    check_channel("color_red",   want.color_red,   got.color_red);
                    check_channel("color_green", want.color_green, got.color_green);
                    check_channel("color_blue",  want.color_blue,  got.color_blue);
                    check_channel("tint_red",    want.tint_red,    got.tint_red);
                    check_channel("tint_green",  want.tint_green,  got.tint_green);
                    check_channel("tint_blue",   want.tint_blue,   got.tint_blue);
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COUNT: shadow_count   = cfg_data[COUNT_W-1:0];
                    REG_STEP:  shadow_step    = cfg_data[TICK_W-1:0];
                    REG_PAIR0: shadow_pair[0] = cfg_data;
                    REG_PAIR1: shadow_pair[1] = cfg_data;
                    REG_PAIR2: shadow_pair[2] = cfg_data;
                    REG_PAIR3: shadow_pair[3] = cfg_data;
                    default: ;  // unmapped index: drop the write
                endcase
            end

            if (s_tvalid && s_tready)
                expected_colors.push_back(predict_color(s_tdata));

            colors_pending = expected_colors.size();
        end
    end

endmodule

// File: bench/palette_color_cycler_tb.sv
// Stimulus and verdict for the palette color cycler: directed tick sequences,
// then random palettes and tick streams with idling on both stream sides.
// Depends on pcc_pkg, palette_color_cycler and palette_color_cycler_checker.
`timescale 1ns / 1ps

module palette_color_cycler_tb;

    import pcc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
    localparam int RANDOM_PHASES = 16;
    localparam int ITEMS_PER_PHASE = 100;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TICK_W-1:0]      s_tdata = '0;       // [31:0] now_tick
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [7:0] color_red, [15:8] color_green, [23:16] color_blue,
    // [31:24] tint_red, [39:32] tint_green, [47:40] tint_blue
    logic [OUT_W-1:0]       m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [PAIR_W-1:0]      cfg_data = '0;

    int                     fail_count;
    int                     colors_pending;
    bit                     steady = 1'b0;
    logic [TICK_W-1:0]      recent_tick = '0;

    palette_color_cycler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    palette_color_cycler_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .colors_pending (colors_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= 23);
    end

    function automatic logic [23:0] rand_color();
        logic [7:0] v;
        v = 8'($urandom);
        case ($urandom_range(0, 5))
            0: return {3{v}};
            1: return 24'h000000;
            2: return 24'hFFFFFF;
            3: return 24'(v) << (8 * $urandom_range(0, 2));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [PAIR_W-1:0] rand_pair();
        return {rand_color(), rand_color()};
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(0, 5))
            0: return 4'd0;
            1: return 4'd1;
            2: return 4'd8;
            3: return 4'($urandom_range(9, 15));
            default: return 4'($urandom_range(2, 7));
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] rand_step();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return $urandom & 32'h0FFF_FFFF;
            2: return $urandom & 32'h00FF_FFFF;
            3: return $urandom;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] next_tick();
        case ($urandom_range(0, 9))
            6, 7: return recent_tick + $urandom_range(0, 65535);
            8: return recent_tick + $urandom;
            9: return $urandom;
            default: return recent_tick + $urandom_range(0, 15);
        endcase
    endfunction

    // Valid stays high from one beat into the next unless a gap is taken.
    task automatic send_tick(input logic [TICK_W-1:0] tick);
        while (!steady && $urandom_range(0, 99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= tick;
        recent_tick  = tick;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_colors();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (colors_pending != 0)
            @(negedge clk);
    endtask

    task automatic load_palette(input logic [COUNT_W-1:0] count,
                                input logic [TICK_W-1:0] step,
                                input logic [PAIR_W-1:0] p0,
                                input logic [PAIR_W-1:0] p1,
                                input logic [PAIR_W-1:0] p2,
                                input logic [PAIR_W-1:0] p3,
                                input bit poke_unmapped);
        logic [PAIR_W-1:0] junk;
        junk = PAIR_W'({$urandom, $urandom});
        @(posedge clk);
        // upper data bits carry junk that the narrow registers must drop
        cfg_we    <= 1'b1;
        cfg_index <= REG_COUNT;
        cfg_data  <= {junk[PAIR_W-1:COUNT_W], count};
        @(posedge clk);
        cfg_index <= REG_STEP;
        cfg_data  <= {junk[PAIR_W-1:TICK_W], step};
        @(posedge clk);
        cfg_index <= REG_PAIR0;
        cfg_data  <= p0;
        @(posedge clk);
        cfg_index <= REG_PAIR1;
        cfg_data  <= p1;
        @(posedge clk);
        cfg_index <= REG_PAIR2;
        cfg_data  <= p2;
        @(posedge clk);
        cfg_index <= REG_PAIR3;
        cfg_data  <= p3;
        @(posedge clk);
        if (poke_unmapped)
        begin
            cfg_index <= $urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO;
            cfg_data  <= PAIR_W'({$urandom, $urandom});
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [COUNT_W-1:0] count;
        logic [TICK_W-1:0]  step;
        logic [TICK_W-1:0]  tick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Two colors, phase step of 2^27 per tick
        load_palette(4'd2, 32'h0800_0000, {24'h00FF40, 24'hFF8000}, 48'h0, 48'h0, 48'h0,
                     1'b0);
        send_tick(32'hFFFF_FFF0);   // first beat: latch the tick, phase holds
        send_tick(32'h0000_0010);   // wrapped delta of a whole cycle: phase holds
        send_tick(32'h0000_0011);
        send_tick(32'h0000_0011);   // zero delta
        send_tick(32'h0000_0014);
        send_tick(32'h0000_001B);
        drain_colors();

        // Count zero, grey palette, near-full step so one tick wraps the phase
        load_palette(4'd0, 32'hFFFF_FFFF, {24'h404040, 24'h808080},
                     {24'hFFFFFF, 24'h000000}, rand_pair(), rand_pair(), 1'b1);
        send_tick(32'h0000_001C);
        send_tick(32'h0000_001E);   // two ticks exceed a whole cycle
        send_tick(32'h0000_001E);
        send_tick(32'hAAAA_AAAA);
        send_tick(32'h5555_5555);
        drain_colors();

        // Count above the maximum saturates; walk every entry and wrap
        load_palette(4'd15, 32'h1000_0000, {24'hFFFFFF, 24'h000000},
                     {24'h00FF00, 24'hFF0000}, {24'h123456, 24'h0000FF},
                     {24'h7F7F7F, 24'hFEDCBA}, 1'b1);
        tick = 32'h5555_5555;
        for (int i = 0; i < 10; i++)
        begin
            tick = tick + ((i % 2) ? 32'd3 : 32'd1);
            send_tick(tick);
        end
        drain_colors();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            count = (ph == 2) ? 4'd8 : (ph == 3) ? 4'd1 : rand_count();
            step  = (ph == 1) ? 32'd0 : rand_step();
            load_palette(count, step, rand_pair(), rand_pair(), rand_pair(), rand_pair(),
                         $urandom_range(0, 3) == 0);
            steady = (ph == 5);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_tick(next_tick());
            drain_colors();
            steady = 1'b0;
        end

        repeat (40) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && colors_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
